// ===== rtl/core/cop_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cop_pkg
// shared types, register indexes, status codes and the square root step
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int unsigned SizeBits   = 13;
  localparam int unsigned CenterBits = 12;
  localparam int unsigned RadiusBits = 11;
  localparam int unsigned ColorBits  = 24;
  localparam int unsigned OffsetBits = 12;
  localparam int unsigned SquareBits = 2 * RadiusBits;
  localparam int unsigned RemBits    = RadiusBits + 1;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CENTER_COL    = 3'd2,
    REG_CENTER_ROW    = 3'd3,
    REG_CIRCLE_RADIUS = 3'd4,
    REG_FILL_COLOR    = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OUTSIDE  = 2'd1,
    STATUS_TOO_BIG  = 2'd2,
    STATUS_TOO_FAR  = 2'd3
  } status_e;

  typedef struct packed {
    logic [SizeBits-1:0]   image_width;
    logic [SizeBits-1:0]   image_height;
    logic [CenterBits-1:0] center_col;
    logic [CenterBits-1:0] center_row;
    logic [RadiusBits-1:0] circle_radius;
    logic [ColorBits-1:0]  fill_color;
  } cfg_t;

  typedef struct packed {
    logic                  func;
    logic                  neg;
    logic [OffsetBits-1:0] mag;
    status_e               status;
  } item_t;

  typedef struct packed {
    logic [RemBits-1:0]    rem;
    logic [RadiusBits-1:0] root;
  } root_t;

  typedef struct packed {
    item_t                 item;
    logic [SquareBits-1:0] n;
  } sq_in_t;

  typedef struct packed {
    item_t item;
    root_t res;
  } sq_out_t;

  typedef struct packed {
    status_e               status;
    logic [SizeBits-1:0]   first_col;
    logic [SizeBits-1:0]   first_row;
    logic [SizeBits-1:0]   second_col;
    logic [SizeBits-1:0]   second_row;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
  } result_t;

  // one digit of the restoring square root, two radicand bits in
  function automatic root_t sqrt_step(root_t cur, logic [1:0] pair);
    logic [RemBits+1:0] acc;
    logic [RemBits+1:0] trial;
    root_t              nxt;
    acc   = {cur.rem, pair};
    trial = {1'b0, cur.root, 2'b01};
    if (acc >= trial) begin
      nxt.rem  = RemBits'(acc - trial);
      nxt.root = {cur.root[RadiusBits-2:0], 1'b1};
    end else begin
      nxt.rem  = acc[RemBits-1:0];
      nxt.root = {cur.root[RadiusBits-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cop_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cop_prep
// three stages: offset magnitude and status, squares, radicand
// ----------------------------------------------------------------------------
module cop_prep (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cop_pkg::cfg_t                  cfg_i,
  input  wire logic                           valid_i,
  output logic                                ready_o,
  input  wire logic                           func_i,
  input  wire logic [cop_pkg::OffsetBits-1:0] offset_i,
  output logic                                valid_o,
  input  wire logic                           ready_i,
  output cop_pkg::sq_in_t                     data_o
);

  logic [2:0] valid_q;
  logic [2:0] rdy;

  cop_pkg::item_t a_item_d, a_item_q;
  cop_pkg::item_t b_item_q, c_item_q;
  logic [cop_pkg::SquareBits-1:0] b_rr_q, b_mm_q, c_n_q, c_n_d;
  logic [cop_pkg::SquareBits-1:0] rad_w, mag_w;

  logic [cop_pkg::SizeBits-1:0] cc_ext, cr_ext, dx, dy, r_ext;
  logic                         outside, too_big, too_far;

  assign rdy[2]  = !valid_q[2] || ready_i;
  assign rdy[1]  = !valid_q[1] || rdy[2];
  assign rdy[0]  = !valid_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_comb begin
    cc_ext  = {1'b0, cfg_i.center_col};
    cr_ext  = {1'b0, cfg_i.center_row};
    r_ext   = {2'b00, cfg_i.circle_radius};
    dx      = ((cfg_i.image_width - cc_ext) < cc_ext) ? cfg_i.image_width - cc_ext : cc_ext;
    dy      = ((cfg_i.image_height - cr_ext) < cr_ext) ? cfg_i.image_height - cr_ext : cr_ext;
    outside = (cc_ext >= cfg_i.image_width) || (cr_ext >= cfg_i.image_height);
    too_big = (r_ext >= dx) || (r_ext >= dy);

    a_item_d.func = func_i;
    a_item_d.neg  = offset_i[cop_pkg::OffsetBits-1];
    a_item_d.mag  = a_item_d.neg ? -offset_i : offset_i;
    too_far       = a_item_d.mag > {1'b0, cfg_i.circle_radius};
    if (outside) begin
      a_item_d.status = cop_pkg::STATUS_OUTSIDE;
    end else if (too_big) begin
      a_item_d.status = cop_pkg::STATUS_TOO_BIG;
    end else if (too_far) begin
      a_item_d.status = cop_pkg::STATUS_TOO_FAR;
    end else begin
      a_item_d.status = cop_pkg::STATUS_OK;
    end

    rad_w = {{(cop_pkg::SquareBits-cop_pkg::RadiusBits){1'b0}}, cfg_i.circle_radius};
    mag_w = {{(cop_pkg::SquareBits-cop_pkg::RadiusBits){1'b0}},
             a_item_q.mag[cop_pkg::RadiusBits-1:0]};

    c_n_d = (b_item_q.status == cop_pkg::STATUS_OK) ? b_rr_q - b_mm_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      a_item_q <= a_item_d;
    end
    if (rdy[1] && valid_q[0]) begin
      b_item_q <= a_item_q;
      b_rr_q   <= rad_w * rad_w;
      b_mm_q   <= mag_w * mag_w;
    end
    if (rdy[2] && valid_q[1]) begin
      c_item_q <= b_item_q;
      c_n_q    <= c_n_d;
    end
  end

  assign valid_o     = valid_q[2];
  assign data_o.item = c_item_q;
  assign data_o.n    = c_n_q;

endmodule
`default_nettype wire

// ===== rtl/core/cop_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cop_sqrt
// pipelined restoring square root, four, four and three digits per stage
// ----------------------------------------------------------------------------
module cop_sqrt (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire cop_pkg::sq_in_t  data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cop_pkg::sq_out_t      data_o
);

  localparam int unsigned Digits = cop_pkg::RadiusBits;

  logic [2:0] valid_q;
  logic [2:0] rdy;

  cop_pkg::sq_in_t s0_in_q, s1_in_q, s2_in_q;
  cop_pkg::root_t  s0_d, s1_d, s2_d;
  cop_pkg::root_t  s0_q, s1_q, s2_q;

  assign rdy[2]  = !valid_q[2] || ready_i;
  assign rdy[1]  = !valid_q[1] || rdy[2];
  assign rdy[0]  = !valid_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_comb begin
    s0_d = '0;
    for (int i = 0; i < 4; i++) begin
      s0_d = cop_pkg::sqrt_step(s0_d, data_i.n[2*(Digits-1-i) +: 2]);
    end
    s1_d = s0_q;
    for (int i = 4; i < 8; i++) begin
      s1_d = cop_pkg::sqrt_step(s1_d, s0_in_q.n[2*(Digits-1-i) +: 2]);
    end
    s2_d = s1_q;
    for (int i = 8; i < Digits; i++) begin
      s2_d = cop_pkg::sqrt_step(s2_d, s1_in_q.n[2*(Digits-1-i) +: 2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      s0_in_q <= data_i;
      s0_q    <= s0_d;
    end
    if (rdy[1] && valid_q[0]) begin
      s1_in_q <= s0_in_q;
      s1_q    <= s1_d;
    end
    if (rdy[2] && valid_q[1]) begin
      s2_in_q <= s1_in_q;
      s2_q    <= s2_d;
    end
  end

  assign valid_o     = valid_q[2];
  assign data_o.item = s2_in_q.item;
  assign data_o.res  = s2_q;

`ifndef NO_ASSERTIONS
  // after four digits only the low four root bits can be set
  a_first_digits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> (s0_q.root[Digits-1:4] == '0))
    else $error("root has bits above the digits done");

  // remainder of a finished root never exceeds twice the root
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> ({1'b0, s2_q.rem} <= {1'b0, s2_q.root, 1'b0}))
    else $error("square root remainder out of range");

  // a stalled last stage keeps its root
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] && !ready_i |=> valid_q[2] && $stable(s2_q))
    else $error("last root stage changed under stall");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/cop_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cop_out
// rounding of the root, outline coordinates and the output register
// ----------------------------------------------------------------------------
module cop_out (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cop_pkg::cfg_t    cfg_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire cop_pkg::sq_out_t data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cop_pkg::result_t      data_o
);

  logic                               valid_q;
  cop_pkg::result_t                   res_d, res_q;
  logic [cop_pkg::RemBits-1:0]        root_ext, s;
  logic [cop_pkg::SizeBits-1:0]       cc_ext, cr_ext, s_ext, mag_ext, line;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    root_ext = {1'b0, data_i.res.root};
    s        = root_ext + {{(cop_pkg::RemBits-1){1'b0}}, (data_i.res.rem > root_ext)};
    cc_ext   = {1'b0, cfg_i.center_col};
    cr_ext   = {1'b0, cfg_i.center_row};
    s_ext    = {1'b0, s};
    mag_ext  = {1'b0, data_i.item.mag};

    res_d.status = data_i.item.status;
    res_d.red    = cfg_i.fill_color[23:16];
    res_d.green  = cfg_i.fill_color[15:8];
    res_d.blue   = cfg_i.fill_color[7:0];
    line         = '0;
    res_d.first_col  = '0;
    res_d.first_row  = '0;
    res_d.second_col = '0;
    res_d.second_row = '0;
    if (data_i.item.status == cop_pkg::STATUS_OK) begin
      if (!data_i.item.func) begin
        line             = data_i.item.neg ? cc_ext - mag_ext : cc_ext + mag_ext;
        res_d.first_col  = line;
        res_d.second_col = line;
        res_d.first_row  = cr_ext + s_ext;
        res_d.second_row = cr_ext - s_ext;
      end else begin
        line             = data_i.item.neg ? cr_ext - mag_ext : cr_ext + mag_ext;
        res_d.first_row  = line;
        res_d.second_row = line;
        res_d.first_col  = cc_ext + s_ext;
        res_d.second_col = cc_ext - s_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/circle_outline_point_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_outline_point_generator_top
// circle outline points for one swept column or row
// ----------------------------------------------------------------------------
// Requests enter on the in channel (func, sweep offset) under valid/ready and
// leave on the out channel with status, two outline points and the fill
// colour channels. The circle and image are set through the write port
// (write enable, register index, data). The user must set them only while
// no request is in flight; the block itself does not enforce this.
// Requests pass three stages for the status check, the squares and the
// radicand, three stages of the square root (four, four and three digits)
// and the output register. One request is taken every cycle while
// out_ready_i stays high. Each stage holds its own valid bit, so when the
// receiver stalls the stages fill up and in_ready_o falls only once all
// seven are full; nothing is lost or repeated. Reset empties the pipeline
// and loads the register reset values (1024 by 1024 image, centre and
// radius zero, colour black). Coordinates are wrapped to COORD_BITS bits.
// ----------------------------------------------------------------------------
module circle_outline_point_generator_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cop_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [cop_pkg::ColorBits-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           func_i,
  input  wire logic [cop_pkg::OffsetBits-1:0] sweep_offset_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          status_o,
  output logic [COORD_BITS-1:0]               first_col_o,
  output logic [COORD_BITS-1:0]               first_row_o,
  output logic [COORD_BITS-1:0]               second_col_o,
  output logic [COORD_BITS-1:0]               second_row_o,
  output logic [7:0]                          red_o,
  output logic [7:0]                          green_o,
  output logic [7:0]                          blue_o
);

  cop_pkg::cfg_t    cfg_q;
  cop_pkg::sq_in_t  prep_data;
  cop_pkg::sq_out_t root_data;
  cop_pkg::result_t res;
  logic             prep_valid, prep_ready, root_valid, root_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= 13'd1024;
      cfg_q.image_height  <= 13'd1024;
      cfg_q.center_col    <= '0;
      cfg_q.center_row    <= '0;
      cfg_q.circle_radius <= '0;
      cfg_q.fill_color    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cop_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i[cop_pkg::SizeBits-1:0];
        cop_pkg::REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i[cop_pkg::SizeBits-1:0];
        cop_pkg::REG_CENTER_COL:    cfg_q.center_col    <= cfg_data_i[cop_pkg::CenterBits-1:0];
        cop_pkg::REG_CENTER_ROW:    cfg_q.center_row    <= cfg_data_i[cop_pkg::CenterBits-1:0];
        cop_pkg::REG_CIRCLE_RADIUS: cfg_q.circle_radius <= cfg_data_i[cop_pkg::RadiusBits-1:0];
        cop_pkg::REG_FILL_COLOR:    cfg_q.fill_color    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cop_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .func_i   (func_i),
    .offset_i (sweep_offset_i),
    .valid_o  (prep_valid),
    .ready_i  (prep_ready),
    .data_o   (prep_data)
  );

  cop_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (root_valid),
    .ready_i (root_ready),
    .data_o  (root_data)
  );

  cop_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (root_valid),
    .ready_o (root_ready),
    .data_i  (root_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res)
  );

  assign status_o     = res.status;
  assign first_col_o  = COORD_BITS'(res.first_col);
  assign first_row_o  = COORD_BITS'(res.first_row);
  assign second_col_o = COORD_BITS'(res.second_col);
  assign second_row_o = COORD_BITS'(res.second_row);
  assign red_o        = res.red;
  assign green_o      = res.green;
  assign blue_o       = res.blue;

endmodule
`default_nettype wire
